// ----- design/hpsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsd_pkg
// Shared constants for the Hausdorff point set distance block.
// ----------------------------------------------------------------------------
package hpsd_pkg;

    localparam int ACT_W   = 2;
    localparam int FIELD_W = 16;
    localparam int DIST_W  = 17;

    localparam int DEF_MAX_POINTS = 256;
    localparam int DEF_COORD_BITS = 16;
    localparam int DEF_NUM_CELLS  = 8;

    localparam logic [ACT_W-1:0] ACT_ADD_A   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_ADD_B   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_COMPUTE = 2'd2;

endpackage

// ----- design/hpsd_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsd_if
// Valid/ready channels: point/command beats in, distance beats out.
// ----------------------------------------------------------------------------
interface hpsd_in_if;
    logic                                valid;
    logic                                ready;
    logic [hpsd_pkg::ACT_W-1:0]          action;
    logic signed [hpsd_pkg::FIELD_W-1:0] point_x;
    logic signed [hpsd_pkg::FIELD_W-1:0] point_y;

    modport source (output valid, action, point_x, point_y, input ready);
    modport sink   (input valid, action, point_x, point_y, output ready);
endinterface

interface hpsd_out_if;
    logic                        valid;
    logic                        ready;
    logic [hpsd_pkg::DIST_W-1:0] distance;
    logic                        either_empty;
    logic                        overflowed;

    modport source (output valid, distance, either_empty, overflowed, input ready);
    modport sink   (input valid, distance, either_empty, overflowed, output ready);
endinterface

// ----- design/hpsd_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsd_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hpsd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/hpsd_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsd_cell
// One cell of the distance chain: holds a source point and its running
// minimum squared distance; passes target points on to the next cell.
// ----------------------------------------------------------------------------
module hpsd_cell #(
    parameter int CW = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // target point chain
    input  logic [CW-1:0]     i_px,
    input  logic [CW-1:0]     i_py,
    input  logic              i_pv,
    output logic [CW-1:0]     o_px,
    output logic [CW-1:0]     o_py,
    output logic              o_pv,
    // source point / minimum shift chain
    input  logic              i_shift,
    input  logic [CW-1:0]     i_sx,
    input  logic [CW-1:0]     i_sy,
    input  logic              i_sv,
    input  logic [2*CW:0]     i_smin,
    output logic [CW-1:0]     o_sx,
    output logic [CW-1:0]     o_sy,
    output logic              o_sv,
    output logic [2*CW:0]     o_smin
);

    localparam int SQ_W = 2 * CW + 1;

    logic [CW-1:0]     r_px, r_py, r_sx, r_sy;
    logic              r_pv, r_sv, r_av, r_bv;
    logic [CW-1:0]     r_ax, r_ay;
    logic [2*CW-1:0]   r_sqx, r_sqy;
    logic [SQ_W-1:0]   r_min;

    logic signed [CW:0] w_dx, w_dy;
    logic [CW:0]        w_ndx, w_ndy;
    logic [CW-1:0]      w_ax, w_ay;
    logic [2*CW-1:0]    w_sqx, w_sqy;
    logic [SQ_W-1:0]    w_sum;

    assign w_dx  = $signed({r_px[CW-1], r_px}) - $signed({r_sx[CW-1], r_sx});
    assign w_dy  = $signed({r_py[CW-1], r_py}) - $signed({r_sy[CW-1], r_sy});
    assign w_ndx = -w_dx;
    assign w_ndy = -w_dy;
    assign w_ax  = w_dx[CW] ? w_ndx[CW-1:0] : w_dx[CW-1:0];
    assign w_ay  = w_dy[CW] ? w_ndy[CW-1:0] : w_dy[CW-1:0];
    assign w_sqx = r_ax * r_ax;
    assign w_sqy = r_ay * r_ay;
    assign w_sum = {1'b0, r_sqx} + {1'b0, r_sqy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_av <= 1'b0;
            r_bv <= 1'b0;
            r_sv <= 1'b0;
        end else begin
            r_pv <= i_pv;
            r_av <= r_pv;
            r_bv <= r_av;
            if (i_shift) begin
                r_sv <= i_sv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_px  <= i_px;
        r_py  <= i_py;
        r_ax  <= w_ax;
        r_ay  <= w_ay;
        r_sqx <= w_sqx;
        r_sqy <= w_sqy;
        if (i_shift) begin
            r_sx  <= i_sx;
            r_sy  <= i_sy;
            r_min <= i_smin;
        end else if (r_bv && (w_sum < r_min)) begin
            r_min <= w_sum;
        end
    end

    assign o_px   = r_px;
    assign o_py   = r_py;
    assign o_pv   = r_pv;
    assign o_sx   = r_sx;
    assign o_sy   = r_sy;
    assign o_sv   = r_sv;
    assign o_smin = r_min;

endmodule

// ----- design/hpsd_sqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hpsd_sqrt
// Floored integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module hpsd_sqrt #(
    parameter int RAD_W = 33
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [RAD_W-1:0]        i_rad,
    output logic                    o_done,
    output logic [(RAD_W+1)/2-1:0]  o_root
);

    localparam int RW    = (RAD_W + 1) / 2;
    localparam int PW    = 2 * RW;
    localparam int CNT_W = $clog2(RW);

    logic [PW-1:0]    r_rad;
    logic [RW+1:0]    r_rem;
    logic [RW-1:0]    r_root;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy, r_done;

    logic [RW+3:0]    w_rem_sh, w_trial, w_diff;
    logic             w_ge;

    assign w_rem_sh = {r_rem, r_rad[PW-1:PW-2]};
    assign w_trial  = (RW + 4)'({r_root, 2'b01});
    assign w_ge     = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= PW'(i_rad);
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CNT_W'(RW - 1);
        end else if (r_busy) begin
            r_rad <= {r_rad[PW-3:0], 2'b00};
            r_cnt <= r_cnt - 1'b1;
            if (w_ge) begin
                r_rem  <= w_diff[RW+1:0];
                r_root <= {r_root[RW-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh[RW+1:0];
                r_root <= {r_root[RW-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// ----- design/hausdorff_point_set_distance.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hausdorff_point_set_distance
// Symmetric Hausdorff distance of two 2D point sets on a chain of cells.
// ----------------------------------------------------------------------------
//  Channel | Dir | Beat                                   | Beats
//  i_in    | in  | action, point_x, point_y               | load or compute
//  o_out   | out | distance, either_empty, overflowed     | one per compute
//
//  A compute beat runs both directions: each block of NUM_CELLS source
//  points is shifted into the chain, the other set streams past it and the
//  chain drains; the chain is then flushed and the root unit runs.
//  i_in is held off for the whole compute; loads are taken while a result
//  waits on o_out. Reset is synchronous; the stores need no clearing.
// ----------------------------------------------------------------------------
module hausdorff_point_set_distance #(
    parameter int MAX_POINTS = hpsd_pkg::DEF_MAX_POINTS,
    parameter int COORD_BITS = hpsd_pkg::DEF_COORD_BITS,
    parameter int NUM_CELLS  = hpsd_pkg::DEF_NUM_CELLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hpsd_in_if.sink     i_in,
    hpsd_out_if.source  o_out
);

    localparam int CW     = (COORD_BITS < 16) ? COORD_BITS : 16;
    localparam int SQ_W   = 2 * CW + 1;
    localparam int RW     = (SQ_W + 1) / 2;
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);
    localparam int BASE_W = $clog2(MAX_POINTS + NUM_CELLS + 1);
    localparam int KW     = $clog2(NUM_CELLS);
    localparam int WAIT_W = $clog2(NUM_CELLS + 5);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SHIFT  = 3'd1;
    localparam logic [2:0] S_STREAM = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;
    localparam logic [2:0] S_SETTLE = 3'd5;
    localparam logic [2:0] S_ROOT   = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    logic [2:0]        r_state;
    logic [CNT_W-1:0]  r_cnt_a, r_cnt_b;
    logic              r_ovf, r_empty, r_dir, r_go;
    logic [BASE_W-1:0] r_base;
    logic [KW-1:0]     r_k;
    logic [AW-1:0]     r_j;
    logic [WAIT_W-1:0] r_wait;
    logic [SQ_W-1:0]   r_max;
    logic              r_iss_shift, r_iss_stream, r_iss_inr, r_iss_sel_a;
    logic              r_out_valid, r_out_empty, r_out_ovf;
    logic [hpsd_pkg::DIST_W-1:0] r_out_dist;

    logic              w_acc, w_we_a, w_we_b, w_out_load;
    logic [CNT_W-1:0]  w_ns, w_nd;
    logic [BASE_W-1:0] w_idx, w_base_nx;
    logic              w_shift, w_stream, w_inr, w_sel_a;
    logic [AW-1:0]     w_raddr;
    logic [2*CW-1:0]   w_wdata, w_rdata_a, w_rdata_b, w_rdata;
    logic              w_root_done;
    logic [RW-1:0]     w_root;

    logic [CW-1:0]     w_px   [NUM_CELLS+1];
    logic [CW-1:0]     w_py   [NUM_CELLS+1];
    logic              w_pv   [NUM_CELLS+1];
    logic [CW-1:0]     w_sx   [NUM_CELLS+1];
    logic [CW-1:0]     w_sy   [NUM_CELLS+1];
    logic              w_sv   [NUM_CELLS+1];
    logic [SQ_W-1:0]   w_smin [NUM_CELLS+1];

    // input side
    assign i_in.ready = (r_state == S_IDLE);
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_wdata    = {i_in.point_x[CW-1:0], i_in.point_y[CW-1:0]};
    assign w_we_a     = w_acc && (i_in.action == hpsd_pkg::ACT_ADD_A)
                        && (r_cnt_a != CNT_W'(MAX_POINTS));
    assign w_we_b     = w_acc && (i_in.action == hpsd_pkg::ACT_ADD_B)
                        && (r_cnt_b != CNT_W'(MAX_POINTS));

    // read issue
    assign w_ns      = r_dir ? r_cnt_b : r_cnt_a;
    assign w_nd      = r_dir ? r_cnt_a : r_cnt_b;
    assign w_idx     = r_base + BASE_W'(r_k);
    assign w_base_nx = r_base + BASE_W'(NUM_CELLS);
    assign w_shift   = (r_state == S_SHIFT) || (r_state == S_FLUSH);
    assign w_stream  = (r_state == S_STREAM);
    assign w_inr     = (r_state == S_SHIFT) && (w_idx < BASE_W'(w_ns));
    assign w_sel_a   = (r_state == S_SHIFT) ? !r_dir : r_dir;
    assign w_raddr   = (r_state == S_SHIFT) ? w_idx[AW-1:0] : r_j;

    hpsd_ram #(.WIDTH(2 * CW), .DEPTH(MAX_POINTS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (r_cnt_a[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_a)
    );

    hpsd_ram #(.WIDTH(2 * CW), .DEPTH(MAX_POINTS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (r_cnt_b[AW-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata_b)
    );

    assign w_rdata = r_iss_sel_a ? w_rdata_a : w_rdata_b;

    // chain head
    assign w_px[0]   = w_rdata[2*CW-1:CW];
    assign w_py[0]   = w_rdata[CW-1:0];
    assign w_pv[0]   = r_iss_stream;
    assign w_sx[0]   = w_rdata[2*CW-1:CW];
    assign w_sy[0]   = w_rdata[CW-1:0];
    assign w_sv[0]   = r_iss_inr;
    assign w_smin[0] = '1;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        hpsd_cell #(.CW(CW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_px    (w_px[g]),
            .i_py    (w_py[g]),
            .i_pv    (w_pv[g]),
            .o_px    (w_px[g+1]),
            .o_py    (w_py[g+1]),
            .o_pv    (w_pv[g+1]),
            .i_shift (r_iss_shift),
            .i_sx    (w_sx[g]),
            .i_sy    (w_sy[g]),
            .i_sv    (w_sv[g]),
            .i_smin  (w_smin[g]),
            .o_sx    (w_sx[g+1]),
            .o_sy    (w_sy[g+1]),
            .o_sv    (w_sv[g+1]),
            .o_smin  (w_smin[g+1])
        );
    end

    hpsd_sqrt #(.RAD_W(SQ_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_go),
        .i_rad   (r_max),
        .o_done  (w_root_done),
        .o_root  (w_root)
    );

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cnt_a      <= '0;
            r_cnt_b      <= '0;
            r_ovf        <= 1'b0;
            r_go         <= 1'b0;
            r_iss_shift  <= 1'b0;
            r_iss_stream <= 1'b0;
            r_iss_inr    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_iss_shift  <= w_shift;
            r_iss_stream <= w_stream;
            r_iss_inr    <= w_inr;
            r_go         <= 1'b0;

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        case (i_in.action)
                            hpsd_pkg::ACT_ADD_A: begin
                                if (w_we_a) r_cnt_a <= r_cnt_a + 1'b1;
                                else        r_ovf   <= 1'b1;
                            end
                            hpsd_pkg::ACT_ADD_B: begin
                                if (w_we_b) r_cnt_b <= r_cnt_b + 1'b1;
                                else        r_ovf   <= 1'b1;
                            end
                            hpsd_pkg::ACT_COMPUTE: begin
                                r_state <= ((r_cnt_a == '0) || (r_cnt_b == '0))
                                           ? S_DONE : S_SHIFT;
                            end
                            default: ;
                        endcase
                    end
                end
                S_SHIFT: begin
                    if (r_k == KW'(NUM_CELLS - 1)) r_state <= S_STREAM;
                end
                S_STREAM: begin
                    if (r_j == AW'(w_nd - 1'b1)) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (r_wait == WAIT_W'(NUM_CELLS + 3)) begin
                        if (w_base_nx < BASE_W'(w_ns) || !r_dir) r_state <= S_SHIFT;
                        else                                   r_state <= S_FLUSH;
                    end
                end
                S_FLUSH: begin
                    if (r_k == KW'(NUM_CELLS - 1)) r_state <= S_SETTLE;
                end
                S_SETTLE: begin
                    r_go    <= 1'b1;
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (w_root_done) r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_cnt_a <= '0;
                        r_cnt_b <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // sequencer payload
    always_ff @(posedge i_clk) begin
        r_iss_sel_a <= w_sel_a;
        if (r_iss_shift && w_sv[NUM_CELLS] && (w_smin[NUM_CELLS] > r_max)) begin
            r_max <= w_smin[NUM_CELLS];
        end
        case (r_state)
            S_IDLE: begin
                r_empty <= (r_cnt_a == '0) || (r_cnt_b == '0);
                r_max   <= '0;
                r_dir   <= 1'b0;
                r_base  <= '0;
                r_k     <= '0;
                r_j     <= '0;
            end
            S_SHIFT, S_FLUSH: begin
                r_k    <= (r_k == KW'(NUM_CELLS - 1)) ? '0 : r_k + 1'b1;
                r_j    <= '0;
                r_wait <= '0;
            end
            S_STREAM: begin
                r_j <= r_j + 1'b1;
            end
            S_DRAIN: begin
                r_wait <= r_wait + 1'b1;
                if (r_wait == WAIT_W'(NUM_CELLS + 3)) begin
                    if (w_base_nx < BASE_W'(w_ns)) begin
                        r_base <= w_base_nx;
                    end else begin
                        r_base <= '0;
                        r_dir  <= 1'b1;
                    end
                end
            end
            default: ;
        endcase
        if (w_out_load) begin
            r_out_dist  <= r_empty ? '0 : hpsd_pkg::DIST_W'(w_root);
            r_out_empty <= r_empty;
            r_out_ovf   <= r_ovf;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.distance     = r_out_dist;
    assign o_out.either_empty = r_out_empty;
    assign o_out.overflowed   = r_out_ovf;

    // checks
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt_a <= CNT_W'(MAX_POINTS)) && (r_cnt_b <= CNT_W'(MAX_POINTS)))
        else $error("point count beyond capacity");

    a_compute_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (i_in.action == hpsd_pkg::ACT_COMPUTE) && (r_cnt_a != '0)
         && (r_cnt_b != '0)) |=> (r_state == S_SHIFT))
        else $error("compute with both sets loaded did not start the chain");

    a_root_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root_done |-> (r_state == S_ROOT))
        else $error("root unit finished outside the root wait");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_DONE))
        else $error("result beat raised outside the done state");

    a_no_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iss_shift |-> !w_pv[NUM_CELLS] && !r_iss_stream)
        else $error("chain shifted while target points were in flight");

endmodule
